// File: rtl/gqi_pkg.sv
// Package for the gyro quaternion integrator: widths, fixed-point constants,
// controller states, datapath commands and the table of derivative terms.
// No dependencies; every other file of the block imports it.
`default_nettype none

package gqi_pkg;

    localparam int RATE_W = 20;
    localparam int TIME_W = 32;
    localparam int QUAT_W = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [31:0] PI_Q30        = 32'hC90F_DAA2;
    localparam logic [31:0] TIME_RATE_DIV = 32'd5_760_000;
    localparam logic [21:0] M_LIMIT       = 22'h20_0000;
    localparam logic [29:0] THETA_LIMIT   = 30'h2000_0000;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

    // floor(2^53 / TIME_RATE_DIV): quotient estimate is ((N >> 21) * REC_DIV) >> 32,
    // at most two below the true quotient
    localparam logic [31:0] REC_DIV = 32'((64'd1 << 53) / 64'(TIME_RATE_DIV));

    localparam logic [6:0] DIV_LAST  = 7'd63;
    localparam logic [6:0] SQRT_LAST = 7'd31;
    localparam logic [6:0] FIX_LAST  = 7'd1;
    localparam logic [3:0] AXIS_LAST = 4'd2;
    localparam logic [3:0] TERM_LAST = 4'd11;
    localparam logic [3:0] COMP_LAST = 4'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_M, S_SAT_M, S_MUL_T, S_REC_MUL, S_BACK_MUL, S_REM, S_FIX,
        S_TH_STORE, S_MAC_MUL, S_MAC_ADD, S_SUM_C, S_CHECK, S_SQ_MUL, S_SQ_ADD,
        S_SQRT_INIT, S_SQRT, S_SC_INIT, S_DIV_S, S_Q_STORE, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_FIRST, OP_LOAD, OP_MUL_M, OP_SAT_M, OP_MUL_T, OP_REC_MUL,
        OP_BACK_MUL, OP_REM, OP_FIX, OP_DIV_STEP, OP_TH_STORE, OP_MAC_MUL,
        OP_MAC_ADD, OP_SUM_C, OP_SQ_MUL, OP_SQ_ADD, OP_SQRT_INIT, OP_SQRT_STEP,
        OP_SC_INIT, OP_Q_STORE, OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic c_zero;
    } t_sts;

    // one product of the quaternion derivative: q[qi] * theta[ti] into acc[acc]
    typedef struct packed {
        logic [1:0] qi;
        logic [1:0] ti;
        logic [1:0] acc;
        logic       neg;
    } t_term;

    function automatic t_term term_of(input logic [3:0] k);
        t_term t;
        case (k)
            4'd0:    t = '{qi: 2'd1, ti: 2'd0, acc: 2'd0, neg: 1'b0};
            4'd1:    t = '{qi: 2'd2, ti: 2'd1, acc: 2'd0, neg: 1'b0};
            4'd2:    t = '{qi: 2'd3, ti: 2'd2, acc: 2'd0, neg: 1'b0};
            4'd3:    t = '{qi: 2'd0, ti: 2'd0, acc: 2'd1, neg: 1'b0};
            4'd4:    t = '{qi: 2'd2, ti: 2'd2, acc: 2'd1, neg: 1'b0};
            4'd5:    t = '{qi: 2'd3, ti: 2'd1, acc: 2'd1, neg: 1'b1};
            4'd6:    t = '{qi: 2'd0, ti: 2'd1, acc: 2'd2, neg: 1'b0};
            4'd7:    t = '{qi: 2'd1, ti: 2'd2, acc: 2'd2, neg: 1'b1};
            4'd8:    t = '{qi: 2'd3, ti: 2'd0, acc: 2'd2, neg: 1'b0};
            4'd9:    t = '{qi: 2'd0, ti: 2'd2, acc: 2'd3, neg: 1'b0};
            4'd10:   t = '{qi: 2'd1, ti: 2'd1, acc: 2'd3, neg: 1'b0};
            4'd11:   t = '{qi: 2'd2, ti: 2'd0, acc: 2'd3, neg: 1'b1};
            default: t = '{qi: 2'd0, ti: 2'd0, acc: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gqi_if.sv
// Channel interfaces of the gyro quaternion integrator: gyro word in,
// quaternion word out, each with valid/ready. Depends on gqi_pkg.
`default_nettype none

interface gqi_in_if;
    import gqi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic [TIME_W-1:0]        sample_time_ms;
    modport source (output valid, rate_x, rate_y, rate_z, sample_time_ms, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, sample_time_ms, output ready);
endinterface

interface gqi_out_if;
    import gqi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

// File: rtl/gqi_datapath.sv
// Datapath: shared 33x33 multiplier, reciprocal angle divide, radix-2 divider,
// bit-pair square root, quaternion state and output register. Uses gqi_pkg.
`default_nettype none

module gqi_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gqi_pkg::t_cmd                    i_cmd,
    input  logic signed [gqi_pkg::RATE_W-1:0] i_rate_x,
    input  logic signed [gqi_pkg::RATE_W-1:0] i_rate_y,
    input  logic signed [gqi_pkg::RATE_W-1:0] i_rate_z,
    input  logic [gqi_pkg::TIME_W-1:0]        i_time,
    output gqi_pkg::t_sts                    o_sts,
    output logic signed [gqi_pkg::QUAT_W-1:0] o_quat_w,
    output logic signed [gqi_pkg::QUAT_W-1:0] o_quat_x,
    output logic signed [gqi_pkg::QUAT_W-1:0] o_quat_y,
    output logic signed [gqi_pkg::QUAT_W-1:0] o_quat_z
);
    import gqi_pkg::*;

    logic signed [31:0] r_q   [4];
    logic signed [31:0] r_out [4];
    logic signed [19:0] r_rate[3];
    logic signed [30:0] r_th  [3];
    logic signed [63:0] r_acc [4];
    logic signed [32:0] r_c   [4];
    logic [31:0]        r_last;
    logic [31:0]        r_dt;
    logic signed [65:0] r_prod;
    logic [21:0]        r_m;
    logic [63:0]        r_num;
    logic [63:0]        r_s;
    logic [63:0]        r_v;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [63:0]        r_dq;
    logic [31:0]        r_rem;
    logic [31:0]        r_den;

    t_term              term;
    logic [1:0]         sel;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [63:0]        trial;
    logic [31:0]        n_val;
    logic [31:0]        c_mag;
    logic [19:0]        rate_mag;
    logic [29:0]        th_mag;
    logic [30:0]        q_mag;
    logic signed [32:0] c_next[4];

    assign term = term_of(i_cmd.idx);
    assign sel  = i_cmd.idx[1:0];

    assign rate_mag = r_rate[sel][19] ? (~20'(r_rate[sel]) + 20'd1) : 20'(r_rate[sel]);
    assign c_mag    = r_c[sel][32] ? 32'(~r_c[sel] + 33'sd1) : r_c[sel][31:0];
    assign th_mag   = (r_dq > 64'(THETA_LIMIT)) ? THETA_LIMIT : r_dq[29:0];
    assign q_mag    = (r_dq > 64'(ONE_Q30)) ? ONE_Q30 : r_dq[30:0];
    assign n_val    = (r_root == 64'd0) ? 32'd1 : r_root[31:0];

    always_comb begin
        case (i_cmd.op)
            OP_MUL_M: begin
                mul_a = signed'({1'b0, r_dt});
                mul_b = signed'({13'd0, rate_mag});
            end
            OP_MUL_T: begin
                mul_a = signed'({11'd0, r_m});
                mul_b = signed'({1'b0, PI_Q30});
            end
            // top 32 bits of the 53-bit angle numerator times the reciprocal
            OP_REC_MUL: begin
                mul_a = signed'({1'b0, r_prod[52:21]});
                mul_b = signed'({1'b0, REC_DIV});
            end
            // quotient estimate back times the divisor for the remainder
            OP_BACK_MUL: begin
                mul_a = signed'({1'b0, r_prod[63:32]});
                mul_b = signed'({1'b0, TIME_RATE_DIV});
            end
            OP_MAC_MUL: begin
                mul_a = 33'(r_q[term.qi]);
                mul_b = 33'(r_th[term.ti]);
            end
            OP_SQ_MUL: begin
                mul_a = r_c[sel];
                mul_b = r_c[sel];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign rem_sh = {r_rem, r_dq[63]};
    assign rem_ge = rem_sh >= {1'b0, r_den};
    assign trial  = r_root + r_bit;

    // new components: old value plus the rounded derivative sum (minus it for w)
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [63:0] biased;
            logic signed [34:0] rnd;
            biased = r_acc[i] + 64'sh2000_0000;
            rnd    = 35'(biased >>> 30);
            if (i == 0)
                c_next[i] = 33'(35'(r_q[i]) - rnd);
            else
                c_next[i] = 33'(35'(r_q[i]) + rnd);
        end
    end

    assign o_sts.c_zero = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0) && (r_c[3] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0] <= 32'(ONE_Q30);
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
            r_last <= '0;
        end else begin
            case (i_cmd.op)
                OP_FIRST: r_last <= i_time;
                OP_LOAD: begin
                    r_rate[0] <= i_rate_x;
                    r_rate[1] <= i_rate_y;
                    r_rate[2] <= i_rate_z;
                    r_dt      <= i_time - r_last;
                    r_last    <= i_time;
                    for (int i = 0; i < 4; i++) r_acc[i] <= '0;
                end
                OP_MUL_M, OP_MUL_T, OP_MAC_MUL, OP_SQ_MUL: r_prod <= mul_p;
                OP_SAT_M: r_m <= (r_prod > 66'(M_LIMIT)) ? M_LIMIT : r_prod[21:0];
                OP_REC_MUL: begin
                    r_num  <= r_prod[63:0];
                    r_prod <= mul_p;
                end
                OP_BACK_MUL: begin
                    r_dq   <= {32'd0, r_prod[63:32]};
                    r_prod <= mul_p;
                end
                OP_REM: r_rem <= 32'(r_num - r_prod[63:0]);
                // bump the estimate while the remainder still holds a divisor
                OP_FIX: begin
                    if (r_rem >= TIME_RATE_DIV) begin
                        r_dq  <= r_dq + 64'd1;
                        r_rem <= r_rem - TIME_RATE_DIV;
                    end
                end
                OP_DIV_STEP: begin
                    r_dq  <= {r_dq[62:0], rem_ge};
                    r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                end
                OP_TH_STORE: r_th[sel] <= r_rate[sel][19] ? -signed'({1'b0, th_mag})
                                                          : signed'({1'b0, th_mag});
                OP_MAC_ADD: r_acc[term.acc] <= term.neg ? r_acc[term.acc] - r_prod[63:0]
                                                        : r_acc[term.acc] + r_prod[63:0];
                OP_SUM_C: begin
                    for (int i = 0; i < 4; i++) r_c[i] <= c_next[i];
                    r_s <= '0;
                end
                OP_SQ_ADD: r_s <= r_s + (r_prod[63:0] >> 2);
                OP_SQRT_INIT: begin
                    r_v    <= r_s;
                    r_root <= '0;
                    r_bit  <= 64'h4000_0000_0000_0000;
                end
                OP_SQRT_STEP: begin
                    if (r_v >= trial) begin
                        r_v    <= r_v - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                OP_SC_INIT: begin
                    r_dq  <= (64'(c_mag) << 29) + 64'(n_val >> 1);
                    r_rem <= '0;
                    r_den <= n_val;
                end
                OP_Q_STORE: r_q[sel] <= r_c[sel][32] ? -signed'({1'b0, q_mag})
                                                     : signed'({1'b0, q_mag});
                OP_OUT_LOAD: for (int i = 0; i < 4; i++) r_out[i] <= r_q[i];
                default: ;
            endcase
        end
    end

    assign o_quat_w = r_out[0];
    assign o_quat_x = r_out[1];
    assign o_quat_y = r_out[2];
    assign o_quat_z = r_out[3];

endmodule

`default_nettype wire

// File: rtl/gqi_ctrl.sv
// Controller: sequences the datapath through angle, derivative, norm and
// scaling steps and runs both handshakes. Uses gqi_pkg.
`default_nettype none

module gqi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gqi_pkg::t_sts i_sts,
    output gqi_pkg::t_cmd o_cmd
);
    import gqi_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic [6:0] r_cnt, n_cnt;
    logic       r_time_valid, n_time_valid;
    logic       r_out_valid, n_out_valid;
    logic       can_load;

    assign can_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid && r_time_valid) n_state = S_MUL_M;
            S_MUL_M:     n_state = S_SAT_M;
            S_SAT_M:     n_state = S_MUL_T;
            S_MUL_T:     n_state = S_REC_MUL;
            S_REC_MUL:   n_state = S_BACK_MUL;
            S_BACK_MUL:  n_state = S_REM;
            S_REM:       n_state = S_FIX;
            S_FIX:       if (r_cnt == FIX_LAST) n_state = S_TH_STORE;
            S_TH_STORE:  n_state = (r_idx == AXIS_LAST) ? S_MAC_MUL : S_MUL_M;
            S_MAC_MUL:   n_state = S_MAC_ADD;
            S_MAC_ADD:   n_state = (r_idx == TERM_LAST) ? S_SUM_C : S_MAC_MUL;
            S_SUM_C:     n_state = S_CHECK;
            S_CHECK:     n_state = i_sts.c_zero ? S_DONE : S_SQ_MUL;
            S_SQ_MUL:    n_state = S_SQ_ADD;
            S_SQ_ADD:    n_state = (r_idx == COMP_LAST) ? S_SQRT_INIT : S_SQ_MUL;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT:      if (r_cnt == SQRT_LAST) n_state = S_SC_INIT;
            S_SC_INIT:   n_state = S_DIV_S;
            S_DIV_S:     if (r_cnt == DIV_LAST) n_state = S_Q_STORE;
            S_Q_STORE:   n_state = (r_idx == COMP_LAST) ? S_DONE : S_SC_INIT;
            S_DONE:      if (can_load) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = r_idx;
        o_in_ready   = 1'b0;
        n_idx        = r_idx;
        n_cnt        = 7'd0;
        n_time_valid = r_time_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_idx      = 4'd0;
                if (i_in_valid) begin
                    o_cmd.op     = r_time_valid ? OP_LOAD : OP_FIRST;
                    n_time_valid = 1'b1;
                end
            end
            S_MUL_M:     o_cmd.op = OP_MUL_M;
            S_SAT_M:     o_cmd.op = OP_SAT_M;
            S_MUL_T:     o_cmd.op = OP_MUL_T;
            S_REC_MUL:   o_cmd.op = OP_REC_MUL;
            S_BACK_MUL:  o_cmd.op = OP_BACK_MUL;
            S_REM:       o_cmd.op = OP_REM;
            S_FIX: begin
                o_cmd.op = OP_FIX;
                n_cnt    = r_cnt + 7'd1;
            end
            S_DIV_S: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 7'd1;
            end
            S_TH_STORE: begin
                o_cmd.op = OP_TH_STORE;
                n_idx    = (r_idx == AXIS_LAST) ? 4'd0 : r_idx + 4'd1;
            end
            S_MAC_MUL:   o_cmd.op = OP_MAC_MUL;
            S_MAC_ADD: begin
                o_cmd.op = OP_MAC_ADD;
                n_idx    = (r_idx == TERM_LAST) ? 4'd0 : r_idx + 4'd1;
            end
            S_SUM_C:     o_cmd.op = OP_SUM_C;
            S_CHECK:     o_cmd.op = OP_NONE;
            S_SQ_MUL:    o_cmd.op = OP_SQ_MUL;
            S_SQ_ADD: begin
                o_cmd.op = OP_SQ_ADD;
                n_idx    = (r_idx == COMP_LAST) ? 4'd0 : r_idx + 4'd1;
            end
            S_SQRT_INIT: o_cmd.op = OP_SQRT_INIT;
            S_SQRT: begin
                o_cmd.op = OP_SQRT_STEP;
                n_cnt    = r_cnt + 7'd1;
            end
            S_SC_INIT:   o_cmd.op = OP_SC_INIT;
            S_Q_STORE: begin
                o_cmd.op = OP_Q_STORE;
                n_idx    = (r_idx == COMP_LAST) ? 4'd0 : r_idx + 4'd1;
            end
            S_DONE: begin
                if (can_load) begin
                    o_cmd.op    = OP_OUT_LOAD;
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_time_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_time_valid <= n_time_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/gyro_quaternion_integrator.sv
// Top level of the gyro quaternion integrator: joins controller and datapath
// to the two channel interfaces. Depends on gqi_pkg, gqi_if, gqi_ctrl, gqi_datapath.
//
//  channel | dir | word                                   | handshake
//  i_in    | in  | rate_x, rate_y, rate_z, sample_time_ms | valid/ready
//  o_out   | out | quat_w, quat_x, quat_y, quat_z         | valid/ready
//
// Sequence: one word at a time. The first word after reset is taken and gives
// no result. Every later word runs, per axis, the angle steps (reciprocal
// multiply, back multiply, remainder, two correction steps), then the derivative
// products, the norm sum, a square root and four scaling divisions on the one
// divider. An all-zero sum skips the norm and scaling.
// Reset: synchronous, active low; restores the identity quaternion and the
// "no sample seen" flag.
// Stalls: the result sits in an output register, so a word can be taken while
// the previous result still waits; only its final load waits for o_out.ready.
`default_nettype none

module gyro_quaternion_integrator (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gqi_in_if.sink  i_in,
    gqi_out_if.source o_out
);
    import gqi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence the work and own both handshakes
    gqi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // hold state, angles, norm and the output word
    gqi_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rate_x (i_in.rate_x),
        .i_rate_y (i_in.rate_y),
        .i_rate_z (i_in.rate_z),
        .i_time   (i_in.sample_time_ms),
        .o_sts    (sts),
        .o_quat_w (o_out.quat_w),
        .o_quat_x (o_out.quat_x),
        .o_quat_y (o_out.quat_y),
        .o_quat_z (o_out.quat_z)
    );

endmodule

`default_nettype wire

// File: rtl/gqi_checker.sv
// Port-level checker for the gyro quaternion integrator, bound to the top
// level. Depends on gqi_pkg for widths.
`default_nettype none

module gqi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [gqi_pkg::QUAT_W-1:0] i_quat_w,
    input logic signed [gqi_pkg::QUAT_W-1:0] i_quat_x
);
    import gqi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_quat_w) && $stable(i_quat_x))
        else $error("stalled result word changed");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after a word was taken");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_quat_w <= 32'sh4000_0000) && (i_quat_w >= -32'sh4000_0000))
        else $error("quaternion component beyond one");

endmodule

bind gyro_quaternion_integrator gqi_checker u_gqi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quat_w    (o_out.quat_w),
    .i_quat_x    (o_out.quat_x)
);

`default_nettype wire

// File: tb/tb_gyro_quaternion_integrator.sv
// Testbench for the gyro quaternion integrator: drives gyro words, predicts each
// quaternion word in a scoreboard class and compares. Depends on gqi_pkg, gqi_if.
`timescale 1ns / 1ps

module tb_gyro_quaternion_integrator;
    import gqi_pkg::*;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    // Attitude predictor and queue of pending quaternion words.
    class attitude_board;
        longint q[4];
        logic [31:0] prev_ms;
        bit seen;
        quat_t pending[$];
        int errors;

        function void clear();
            q[0] = longint'(1) << 30; q[1] = 0; q[2] = 0; q[3] = 0;
            prev_ms = 0; seen = 0; errors = 0;
        endfunction

        function longint half_angle(logic [31:0] dt, longint rate);
            longint unsigned mag, m, th;
            mag = rate < 0 ? -rate : rate;
            m = longint'(dt) * mag;
            if (m > (64'd1 << 21)) m = 64'd1 << 21;
            th = m * 64'hC90FDAA2 / 64'd5760000;
            if (th > (64'd1 << 29)) th = 64'd1 << 29;
            return rate < 0 ? -longint'(th) : longint'(th);
        endfunction

        function longint round_q30(longint v);
            longint y;
            y = v + (longint'(1) << 29);
            return y >>> 30;   // arithmetic shift is a floor
        endfunction

        function longint unsigned root_of(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + b) begin
                    v -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint scaled(longint c, longint unsigned n);
            longint unsigned mag, r;
            mag = c < 0 ? -c : c;
            r = ((mag << 29) + (n >> 1)) / n;
            if (r > (64'd1 << 30)) r = 64'd1 << 30;
            return c < 0 ? -longint'(r) : longint'(r);
        endfunction

        // Note an accepted gyro word and queue the quaternion it yields.
        function void note_sample(logic signed [19:0] rx, logic signed [19:0] ry,
                                  logic signed [19:0] rz, logic [31:0] ms);
            logic [31:0] dt;
            longint tx, ty, tz, c[4];
            longint unsigned s, n, a;
            quat_t e;
            if (!seen) begin
                prev_ms = ms; seen = 1; return;
            end
            dt = ms - prev_ms; prev_ms = ms;
            tx = half_angle(dt, rx); ty = half_angle(dt, ry); tz = half_angle(dt, rz);
            c[0] = q[0] - round_q30(q[1]*tx + q[2]*ty + q[3]*tz);
            c[1] = q[1] + round_q30(q[0]*tx + q[2]*tz - q[3]*ty);
            c[2] = q[2] + round_q30(q[0]*ty - q[1]*tz + q[3]*tx);
            c[3] = q[3] + round_q30(q[0]*tz + q[1]*ty - q[2]*tx);
            if (c[0] != 0 || c[1] != 0 || c[2] != 0 || c[3] != 0) begin
                s = 0;
                for (int i = 0; i < 4; i++) begin
                    a = c[i] < 0 ? -c[i] : c[i];
                    s += (a * a) >> 2;
                end
                n = root_of(s);
                if (n == 0) n = 1;
                for (int i = 0; i < 4; i++) q[i] = scaled(c[i], n);
            end
            e.w = 32'(q[0]); e.x = 32'(q[1]); e.y = 32'(q[2]); e.z = 32'(q[3]);
            pending.push_back(e);
        endfunction

        // Check one quaternion word against the oldest expectation.
        function void check_quat(quat_t got);
            quat_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++; return;
            end
            e = pending.pop_front();
            if (got.w !== e.w) begin
                $display("%0t: w exp %0d got %0d", $time, e.w, got.w); errors++;
            end
            if (got.x !== e.x) begin
                $display("%0t: x exp %0d got %0d", $time, e.x, got.x); errors++;
            end
            if (got.y !== e.y) begin
                $display("%0t: y exp %0d got %0d", $time, e.y, got.y); errors++;
            end
            if (got.z !== e.z) begin
                $display("%0t: z exp %0d got %0d", $time, e.z, got.z); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    gqi_in_if  in_ch();
    gqi_out_if out_ch();

    gyro_quaternion_integrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    attitude_board board = new();
    int send_idle = 0;      // percent of cycles the sender holds back
    int recv_idle = 0;      // percent of cycles the receiver holds back
    bit hold_off = 0;       // long receiver stall in progress
    logic [31:0] clock_ms = 0;
    longint cycles = 0;

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_sample(in_ch.rate_x, in_ch.rate_y, in_ch.rate_z,
                              in_ch.sample_time_ms);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_quat({out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z});
    end

    // Receiver: change ready at the falling edge.
    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Ends the run if the block hangs; the bound is many slowest runs over.
    always @(posedge i_clk) begin
        if (cycles > 2_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [19:0] pick_rate();
        case ($urandom_range(7))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return 20'h0;
            3: return 20'($urandom);
            default: return 20'($urandom_range(4000) - 2000);
        endcase
    endfunction

    // Offer one gyro word, with random gaps, and hold it until taken.
    // Valid stays high on return so the next word can follow directly.
    task automatic send_word(logic [19:0] rx, logic [19:0] ry, logic [19:0] rz,
                             logic [31:0] ms);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rate_x <= rx; in_ch.rate_y <= ry; in_ch.rate_z <= rz;
        in_ch.sample_time_ms <= ms;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) begin
            // advance the clock mostly by a few ms; sometimes jump or wrap
            case ($urandom_range(19))
                0: clock_ms = $urandom;
                1: clock_ms = clock_ms;
                2: clock_ms = clock_ms + $urandom_range(100000);
                default: clock_ms = clock_ms + $urandom_range(1, 20);
            endcase
            send_word(pick_rate(), pick_rate(), pick_rate(), clock_ms);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.rate_x = '0; in_ch.rate_y = '0; in_ch.rate_z = '0;
        in_ch.sample_time_ms = '0;
        out_ch.ready = 1'b0;
        board.clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first sample, zero dt, extremes, wrap, long gap.
        send_word(20'h0, 20'h0, 20'h0, 32'hFFFF_FFF0);
        send_word(20'h0, 20'h0, 20'h0, 32'hFFFF_FFF0);
        send_word(20'h7FFFF, 20'h0, 20'h0, 32'h0000_0005);
        send_word(20'h80000, 20'h7FFFF, 20'h80000, 32'h0000_0006);
        send_word(20'h0, 20'h80000, 20'h7FFFF, 32'h8000_0000);
        send_word(20'h00001, 20'hFFFFF, 20'h00010, 32'h8000_0001);
        send_word(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 32'h8000_0002);
        send_word(20'h80000, 20'h80000, 20'h80000, 32'h8000_0003);
        send_word(20'h55555, 20'hAAAAA, 20'h12345, 32'hFFFF_FFFF);
        send_word(20'hAAAAA, 20'h55555, 20'hEDCBA, 32'h0000_0000);
        for (int i = 0; i < 8; i++)
            send_word(20'h00F00, 20'hFF100, 20'h00800, 32'd100 + i * 2);
        clock_ms = 32'd200;

        send_idle = 18; recv_idle = 55;
        send_random(230);

        // Long receiver stall while the sender keeps offering words.
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send_random(5);
                in_ch.valid <= 1'b0;
            end
        join
        @(negedge i_clk);

        send_idle = 55; recv_idle = 18;
        send_random(230);
        send_idle = 0; recv_idle = 0;
        send_random(230);
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/gqi_pkg.sv
rtl/gqi_if.sv
rtl/gqi_datapath.sv
rtl/gqi_ctrl.sv
rtl/gyro_quaternion_integrator.sv
rtl/gqi_checker.sv
tb/tb_gyro_quaternion_integrator.sv
